// ----- hw/rtl/pdsc_pkg.sv -----
package pdsc_pkg;

   localparam logic [7:0] HDR_VALUE = 8'hFF;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_ID   = 3'd1,
      PH_CMD  = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4,
      PH_CHI  = 3'd5,
      PH_CLO  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_SKIP = 3'd0,
      ROLE_HDR  = 3'd1,
      ROLE_ID   = 3'd2,
      ROLE_CMD  = 3'd3,
      ROLE_LEN  = 3'd4,
      ROLE_PAY  = 3'd5,
      ROLE_CHI  = 3'd6,
      ROLE_CLO  = 3'd7
   } role_type;

   typedef struct packed {
      logic       checksum_ok;
      logic       packet_end;
      logic [7:0] payload_index;
      role_type   role;
      logic [7:0] out_byte;
   } rsp_type;

endpackage

// ----- hw/rtl/packet_deframer_sum_check.sv -----
// A result word leaves from the result register, waiting first in the skid register
// on a stall. One byte per cycle while the skid register is empty; a two-entry output
// stage (result and skid register) lets a byte be taken while a prior result waits.
// Reset (synchronous, active high) returns the deframer to header hunting, clears
// the running sum, counters and checksum flag, and empties the output stage.
module packet_deframer_sum_check
   import pdsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [15:8] payload_index
   output logic [3:0]  rsp_tuser,   // [2:0] role, [3] checksum_ok
   output logic        rsp_tlast    // packet_end
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;
   logic        chk_hi_ok_ff, chk_hi_ok_in;
   logic [7:0]  pay_count_ff, pay_count_in;

   rsp_type     result;
   rsp_type     rsp_data_ff, skid_data_ff;
   logic        rsp_valid_ff, skid_valid_ff;

   logic        accept;
   logic        take;
   logic [7:0]  b;

   assign b          = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = rsp_valid_ff && rsp_tready;

   // Next phase.
   always_comb begin
      unique case (phase_ff)
         PH_ID:   phase_in = PH_CMD;
         PH_CMD:  phase_in = PH_LEN;
         PH_LEN:  phase_in = (b == 8'd0) ? PH_CHI : PH_DATA;
         PH_DATA: phase_in = (remaining_ff == 8'd1) ? PH_CHI : PH_DATA;
         PH_CHI:  phase_in = PH_CLO;
         PH_CLO:  phase_in = PH_HUNT;
         default: phase_in = (b == HDR_VALUE) ? PH_ID : PH_HUNT;
      endcase
   end

   // Datapath and result word.
   always_comb begin
      remaining_in         = remaining_ff;
      sum_in               = sum_ff;
      chk_hi_ok_in         = chk_hi_ok_ff;
      pay_count_in         = pay_count_ff;
      result.out_byte      = b;
      result.role          = ROLE_SKIP;
      result.payload_index = 8'd0;
      result.packet_end    = 1'b0;
      result.checksum_ok   = 1'b0;
      unique case (phase_ff)
         PH_ID: begin
            result.role = ROLE_ID;
            sum_in      = sum_ff + {8'd0, b};
         end
         PH_CMD: begin
            result.role = ROLE_CMD;
            sum_in      = sum_ff + {8'd0, b};
         end
         PH_LEN: begin
            result.role  = ROLE_LEN;
            sum_in       = sum_ff + {8'd0, b};
            remaining_in = b;
            pay_count_in = 8'd0;
         end
         PH_DATA: begin
            result.role          = ROLE_PAY;
            result.payload_index = pay_count_ff;
            sum_in               = sum_ff + {8'd0, b};
            pay_count_in         = pay_count_ff + 8'd1;
            remaining_in         = remaining_ff - 8'd1;
         end
         PH_CHI: begin
            result.role  = ROLE_CHI;
            chk_hi_ok_in = (b == sum_ff[15:8]);
         end
         PH_CLO: begin
            result.role        = ROLE_CLO;
            result.packet_end  = 1'b1;
            result.checksum_ok = chk_hi_ok_ff && (b == sum_ff[7:0]);
            sum_in             = 16'd0;
            chk_hi_ok_in       = 1'b0;
            remaining_in       = 8'd0;
            pay_count_in       = 8'd0;
         end
         default: begin
            if (b == HDR_VALUE) begin
               result.role  = ROLE_HDR;
               sum_in       = {8'd0, HDR_VALUE};
               chk_hi_ok_in = 1'b0;
               remaining_in = 8'd0;
               pay_count_in = 8'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         remaining_ff <= 8'd0;
         sum_ff       <= 16'd0;
         chk_hi_ok_ff <= 1'b0;
         pay_count_ff <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         chk_hi_ok_ff <= chk_hi_ok_in;
         pay_count_ff <= pay_count_in;
      end
   end

   // The skid register only fills while the result register holds a word
   // that has not been taken; it drains back into the result register first.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept) begin
            rsp_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.payload_index, rsp_data_ff.out_byte};
   assign rsp_tuser  = {rsp_data_ff.checksum_ok, rsp_data_ff.role};
   assign rsp_tlast  = rsp_data_ff.packet_end;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held while result register is empty");

   a_header_starts_packet: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_HUNT) && (req_tdata == HDR_VALUE) |=> phase_ff == PH_ID)
      else $error("header byte did not start a packet");

   a_last_is_check_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_data_ff.role == ROLE_CLO)
      else $error("packet end flagged on a byte other than check low");

   a_ok_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.checksum_ok |-> rsp_data_ff.packet_end)
      else $error("checksum ok flagged away from packet end");

endmodule
